// ===== rtl/mutual_subset_check_core_defines.svh =====
// assertion macros used by the checker
`ifndef MUTUAL_SUBSET_CHECK_CORE_DEFINES_SVH
`define MUTUAL_SUBSET_CHECK_CORE_DEFINES_SVH

// antecedent in this cycle, consequent in the next
`define MSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msc check failed");

// antecedent and consequent in the same cycle
`define MSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msc check failed");

`endif

// ===== rtl/msc_pkg.sv =====
`default_nettype none

package msc_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VALUE_W    = 32;

    // command codes
    localparam logic [1:0] FUNC_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] FUNC_APPEND_SECOND = 2'd1;
    localparam logic [1:0] FUNC_EVAL          = 2'd2;

    // relation codes
    localparam logic [1:0] REL_NONE            = 2'd0;
    localparam logic [1:0] REL_FIRST_IN_SECOND = 2'd1;
    localparam logic [1:0] REL_SECOND_IN_FIRST = 2'd2;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] value;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0] relation;
        logic       overflowed;
    } res_beat_t;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_PASS,
        SCAN_NEEDLE,
        SCAN_WALK,
        SCAN_EMIT
    } scan_state_t;

    // read requests from the scan sequencer to the two list rams
    typedef struct packed {
        logic             first_re;
        logic [IDX_W-1:0] first_raddr;
        logic             second_re;
        logic [IDX_W-1:0] second_raddr;
    } scan_rd_t;

    // status from the scan sequencer
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [1:0] relation;
    } scan_stat_t;

endpackage

`default_nettype wire

// ===== rtl/msc_ram.sv =====
`default_nettype none

module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msc_scan.sv =====
`default_nettype none

module msc_scan (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  res_free,
    input  wire logic [msc_pkg::CNT_W-1:0]   first_count,
    input  wire logic [msc_pkg::CNT_W-1:0]   second_count,
    input  wire logic [msc_pkg::VALUE_W-1:0] first_rdata,
    input  wire logic [msc_pkg::VALUE_W-1:0] second_rdata,
    output msc_pkg::scan_rd_t          rd,
    output msc_pkg::scan_stat_t        stat
);
    import msc_pkg::*;

    scan_state_t      state_reg, state_next;
    logic             pass_reg, pass_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [1:0]       rel_reg, rel_next;

    logic [CNT_W-1:0] outer_cnt, inner_cnt;
    logic [IDX_W-1:0] outer_addr, inner_addr;
    logic             outer_re, inner_re;
    logic             hit;
    logic [1:0]       pass_rel;
    logic             done;

    // pass 0 looks for first in second, pass 1 the reverse
    assign outer_cnt = pass_reg ? second_count : first_count;
    assign inner_cnt = pass_reg ? first_count : second_count;
    assign pass_rel  = pass_reg ? REL_SECOND_IN_FIRST : REL_FIRST_IN_SECOND;
    assign hit       = (first_rdata == second_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_IDLE;
            pass_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            rel_reg   <= REL_NONE;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            rel_reg   <= rel_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        rel_next    = rel_reg;
        outer_re    = 1'b0;
        inner_re    = 1'b0;
        outer_addr  = i_reg;
        inner_addr  = j_reg + IDX_W'(1);
        done        = 1'b0;

        case (state_reg)
            SCAN_IDLE:
            begin
                if (start)
                begin
                    pass_next  = 1'b0;
                    state_next = SCAN_PASS;
                end
            end
            SCAN_PASS:
            begin
                if (outer_cnt == '0)
                begin
                    rel_next   = pass_rel;
                    state_next = SCAN_EMIT;
                end
                else if (inner_cnt == '0)
                begin
                    if (!pass_reg)
                    begin
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        rel_next   = REL_NONE;
                        state_next = SCAN_EMIT;
                    end
                end
                else
                begin
                    i_next     = '0;
                    state_next = SCAN_NEEDLE;
                end
            end
            SCAN_NEEDLE:
            begin
                // fetch needle and the first inner entry together
                outer_re   = 1'b1;
                inner_re   = 1'b1;
                inner_addr = '0;
                j_next     = '0;
                state_next = SCAN_WALK;
            end
            SCAN_WALK:
            begin
                if (hit)
                begin
                    if (CNT_W'(i_reg) + CNT_W'(1) == outer_cnt)
                    begin
                        rel_next   = pass_rel;
                        state_next = SCAN_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        state_next = SCAN_NEEDLE;
                    end
                end
                else if (CNT_W'(j_reg) + CNT_W'(1) == inner_cnt)
                begin
                    // needle missing from inner list
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        state_next = SCAN_PASS;
                    end
                    else
                    begin
                        rel_next   = REL_NONE;
                        state_next = SCAN_EMIT;
                    end
                end
                else
                begin
                    inner_re = 1'b1;
                    j_next   = j_reg + IDX_W'(1);
                end
            end
            SCAN_EMIT:
            begin
                if (res_free)
                begin
                    done       = 1'b1;
                    state_next = SCAN_IDLE;
                end
            end
            default:
            begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    assign rd.first_re     = pass_reg ? inner_re : outer_re;
    assign rd.first_raddr  = pass_reg ? inner_addr : outer_addr;
    assign rd.second_re    = pass_reg ? outer_re : inner_re;
    assign rd.second_raddr = pass_reg ? outer_addr : inner_addr;

    assign stat.busy     = (state_reg != SCAN_IDLE);
    assign stat.done     = done;
    assign stat.relation = rel_reg;

endmodule

`default_nettype wire

// ===== rtl/mutual_subset_check_core.sv =====
// channel | beat type  | handshake            | direction
// cmd     | cmd_beat_t | cmd_valid, cmd_stall | into the core
// res     | res_beat_t | res_valid, res_stall | out of the core
//
// append beats may follow back to back while no evaluate is in progress
// an evaluate walks both lists: per pass, each needle is fetched together with
// the first inner entry, then inner entries are compared until a match or the end
// the walk is bound by the single read port of each list ram, one entry a cycle
// reset clears both counts and the overflow flag; list contents need no clearing
// cmd_stall is high from an accepted evaluate until its result is registered
`default_nettype none

module mutual_subset_check_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire msc_pkg::cmd_beat_t cmd,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output msc_pkg::res_beat_t      res
);
    import msc_pkg::*;

    // list fill levels and the sticky overflow flag
    logic [CNT_W-1:0] first_cnt_reg, first_cnt_next;
    logic [CNT_W-1:0] second_cnt_reg, second_cnt_next;
    logic             ovf_reg, ovf_next;

    // output register separates the result from the scan engine
    logic             res_valid_reg, res_valid_next;
    res_beat_t        res_beat_reg, res_beat_next;

    logic             cmd_accept;
    logic             first_full, second_full;
    logic             first_we, second_we;
    logic             res_free;

    logic [VALUE_W-1:0] first_rdata, second_rdata;

    scan_rd_t   scan_rd;
    scan_stat_t scan_stat;

    // commands are taken only while the scan engine is idle
    assign cmd_stall  = scan_stat.busy;
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign first_full  = (first_cnt_reg == CNT_W'(LIST_DEPTH));
    assign second_full = (second_cnt_reg == CNT_W'(LIST_DEPTH));

    // appends write straight into the tail of the list ram
    assign first_we  = cmd_accept && (cmd.func == FUNC_APPEND_FIRST) && !first_full;
    assign second_we = cmd_accept && (cmd.func == FUNC_APPEND_SECOND) && !second_full;

    // a result can be loaded when the output register is empty or draining
    assign res_free = !res_valid_reg || !res_stall;

    msc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_cnt_reg[IDX_W-1:0]),
        .wdata (cmd.value),
        .re    (scan_rd.first_re),
        .raddr (scan_rd.first_raddr),
        .rdata (first_rdata)
    );

    msc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_cnt_reg[IDX_W-1:0]),
        .wdata (cmd.value),
        .re    (scan_rd.second_re),
        .raddr (scan_rd.second_raddr),
        .rdata (second_rdata)
    );

    msc_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd_accept && (cmd.func == FUNC_EVAL)),
        .res_free     (res_free),
        .first_count  (first_cnt_reg),
        .second_count (second_cnt_reg),
        .first_rdata  (first_rdata),
        .second_rdata (second_rdata),
        .rd           (scan_rd),
        .stat         (scan_stat)
    );

    always_comb
    begin
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        ovf_next        = ovf_reg;
        res_valid_next  = res_valid_reg;
        res_beat_next   = res_beat_reg;

        if (first_we)
        begin
            first_cnt_next = first_cnt_reg + CNT_W'(1);
        end
        if (second_we)
        begin
            second_cnt_next = second_cnt_reg + CNT_W'(1);
        end

        // append to a full list: value dropped, flag set
        if (cmd_accept && (cmd.func == FUNC_APPEND_FIRST) && first_full)
        begin
            ovf_next = 1'b1;
        end
        if (cmd_accept && (cmd.func == FUNC_APPEND_SECOND) && second_full)
        begin
            ovf_next = 1'b1;
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        // evaluate finished: register the result, empty both lists
        if (scan_stat.done)
        begin
            res_valid_next           = 1'b1;
            res_beat_next.relation   = scan_stat.relation;
            res_beat_next.overflowed = ovf_reg;
            first_cnt_next           = '0;
            second_cnt_next          = '0;
            ovf_next                 = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            ovf_reg        <= ovf_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        res_beat_reg <= res_beat_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_beat_reg;

endmodule

`default_nettype wire

// ===== rtl/msc_checker.sv =====
`default_nettype none
`include "mutual_subset_check_core_defines.svh"

module msc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_stall,
    input wire msc_pkg::cmd_beat_t cmd,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire msc_pkg::res_beat_t res
);
    import msc_pkg::*;

    // a stalled result beat stays put
    `MSC_ASSERT_NEXT(res_hold_chk, res_valid && res_stall, res_valid && $stable(res))

    // an accepted evaluate blocks further commands while the lists are walked
    `MSC_ASSERT_NEXT(eval_busy_chk, cmd_valid && !cmd_stall && (cmd.func == FUNC_EVAL),
                     cmd_stall)

    // a new result only appears at the end of an evaluate
    `MSC_ASSERT_SAME(res_src_chk, $rose(res_valid), $past(cmd_stall))

    // relation codes stay within their defined range
    `MSC_ASSERT_SAME(rel_code_chk, res_valid,
                     (res.relation == REL_NONE) || (res.relation == REL_FIRST_IN_SECOND) ||
                     (res.relation == REL_SECOND_IN_FIRST))

endmodule

bind mutual_subset_check_core msc_checker u_msc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

// ===== tb/mutual_subset_check_checker.sv =====
`timescale 1ns / 100ps

module mutual_subset_check_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire logic               cmd_stall,
    input  wire msc_pkg::cmd_beat_t cmd,
    input  wire logic               res_valid,
    input  wire logic               res_stall,
    input  wire msc_pkg::res_beat_t res,
    output int                      errors,
    output int                      pending,
    output int                      checked
);
    import msc_pkg::*;

    // shadow copy of the two lists
    logic [VALUE_W-1:0] first_list [LIST_DEPTH];
    logic [VALUE_W-1:0] second_list [LIST_DEPTH];
    int                 first_len;
    int                 second_len;
    bit                 drop_seen;

    res_beat_t          expected_relations [$];
    res_beat_t          want;

    initial
    begin
        errors     = 0;
        pending    = 0;
        checked    = 0;
        first_len  = 0;
        second_len = 0;
        drop_seen  = 1'b0;
    end

    // every entry of one list found somewhere in the other
    function automatic bit list_within(input bit first_side);
        logic [VALUE_W-1:0] needle;
        bit                 hit;
        int                 a_len;
        int                 b_len;
        a_len = first_side ? first_len : second_len;
        b_len = first_side ? second_len : first_len;
        for (int i = 0; i < a_len; i++)
        begin
            needle = first_side ? first_list[i] : second_list[i];
            hit    = 1'b0;
            for (int j = 0; j < b_len; j++)
            begin
                if ((first_side ? second_list[j] : first_list[j]) == needle)
                    hit = 1'b1;
            end
            if (!hit)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic res_beat_t predict_relation();
        res_beat_t r;
        if (list_within(1'b1))
            r.relation = REL_FIRST_IN_SECOND;
        else if (list_within(1'b0))
            r.relation = REL_SECOND_IN_FIRST;
        else
            r.relation = REL_NONE;
        r.overflowed = drop_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len  = 0;
            second_len = 0;
            drop_seen  = 1'b0;
            expected_relations.delete();
            pending    = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_relations.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got %0d/%0b",
                             $time, res.relation, res.overflowed);
                end
                else
                begin
                    want = expected_relations.pop_front();
                    checked++;
                    if (res.relation !== want.relation)
                    begin
                        errors++;
                        $display("%0t: relation mismatch, expected %0d, got %0d",
                                 $time, want.relation, res.relation);
                    end
                    if (res.overflowed !== want.overflowed)
                    begin
                        errors++;
                        $display("%0t: overflowed mismatch, expected %0b, got %0b",
                                 $time, want.overflowed, res.overflowed);
                    end
                end
            end

            if (cmd_valid && !cmd_stall)
            begin
                case (cmd.func)
                    FUNC_APPEND_FIRST:
                    begin
                        if (first_len < LIST_DEPTH)
                        begin
                            first_list[first_len] = cmd.value;
                            first_len++;
                        end
                        else
                            drop_seen = 1'b1;
                    end
                    FUNC_APPEND_SECOND:
                    begin
                        if (second_len < LIST_DEPTH)
                        begin
                            second_list[second_len] = cmd.value;
                            second_len++;
                        end
                        else
                            drop_seen = 1'b1;
                    end
                    FUNC_EVAL:
                    begin
                        expected_relations.push_back(predict_relation());
                        first_len  = 0;
                        second_len = 0;
                        drop_seen  = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            pending = expected_relations.size();
        end
    end

endmodule

// ===== tb/tb_mutual_subset_check_core.sv =====
`timescale 1ns / 100ps

module tb_mutual_subset_check_core;
    import msc_pkg::*;

    // unused command code, the core must ignore it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int TARGET_BEATS = 1000;
    // last stretch of the run goes without any idling on either side
    localparam int CALM_AFTER   = 850;
    // a handful of full-depth evaluates plus about a hundred small sets,
    // with stalls, stays far below this
    localparam int CYCLE_LIMIT  = 1_000_000;
    // nothing is in flight once the last result has gone, a short tail catches strays
    localparam int TAIL_CYCLES  = 40;

    typedef enum int {
        SHAPE_FIRST_IN_SECOND,
        SHAPE_SECOND_IN_FIRST,
        SHAPE_POOL,
        SHAPE_WIDE
    } set_shape_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_beat_t cmd;
    logic      res_valid;
    logic      res_stall;
    res_beat_t res;

    int errors;
    int pending;
    int checked;

    int beats_sent    = 0;
    int evals_sent    = 0;
    int overflow_sets = 0;
    int cycles        = 0;
    bit calm          = 1'b0;
    int send_idle_pct = 20;
    int recv_idle_pct = 20;
    int stall_left    = 0;

    // small value pool so that lists share members and containment happens
    logic [VALUE_W-1:0] value_pool [8];

    mutual_subset_check_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    mutual_subset_check_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cycle count, receiver idle rate reselection and the run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 128 == 0)
        begin
            case ($urandom_range(0, 2))
                0: recv_idle_pct = 0;
                1: recv_idle_pct = 15;
                default: recv_idle_pct = 45;
            endcase
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // result side backpressure in short random bursts
    always @(negedge clk)
    begin
        if (rst_n && stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
            if (rst_n && !calm && $urandom_range(0, 99) < recv_idle_pct)
                stall_left = $urandom_range(1, 3);
        end
    end

    // optional idle burst ahead of the next beat
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 99) < send_idle_pct)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
            end
        end
    endtask

    // drive one command beat and hold it until the core takes it
    task automatic send_beat(input logic [1:0] func, input logic [VALUE_W-1:0] value);
        cmd_beat_t beat;
        beat.func  = func;
        beat.value = value;
        sender_gap();
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= beat;
        do
            @(posedge clk);
        while (cmd_stall);
        if (func != FUNC_UNUSED)
            beats_sent++;
        if (func == FUNC_EVAL)
            evals_sent++;
    endtask

    // stop sending until every evaluate has returned its result
    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pool_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // one load of both lists followed by an evaluate
    task automatic send_set(input int first_n, input int second_n,
                            input set_shape_t shape, input bit hold_off);
        logic [VALUE_W-1:0] first_vals [$];
        logic [VALUE_W-1:0] second_vals [$];
        int                 pool_span;
        for (int i = 0; i < 8; i++)
            value_pool[i] = pool_value();
        pool_span = $urandom_range(0, 7);

        case (shape)
            SHAPE_FIRST_IN_SECOND:
            begin
                for (int i = 0; i < second_n; i++)
                    second_vals.push_back(value_pool[$urandom_range(0, pool_span)]);
                for (int i = 0; i < first_n; i++)
                    first_vals.push_back(second_n == 0 ? value_pool[$urandom_range(0, 7)] :
                                         second_vals[$urandom_range(0, second_n - 1)]);
            end
            SHAPE_SECOND_IN_FIRST:
            begin
                for (int i = 0; i < first_n; i++)
                    first_vals.push_back(value_pool[$urandom_range(0, pool_span)]);
                for (int i = 0; i < second_n; i++)
                    second_vals.push_back(first_n == 0 ? value_pool[$urandom_range(0, 7)] :
                                          first_vals[$urandom_range(0, first_n - 1)]);
            end
            SHAPE_POOL:
            begin
                for (int i = 0; i < first_n; i++)
                    first_vals.push_back(value_pool[$urandom_range(0, pool_span)]);
                for (int i = 0; i < second_n; i++)
                    second_vals.push_back(value_pool[$urandom_range(0, pool_span)]);
            end
            default:
            begin
                for (int i = 0; i < first_n; i++)
                    first_vals.push_back($urandom);
                for (int i = 0; i < second_n; i++)
                    second_vals.push_back($urandom);
            end
        endcase

        if (first_n > LIST_DEPTH || second_n > LIST_DEPTH)
            overflow_sets++;

        // interleave the two lists, with the odd ignored beat as noise
        while (first_vals.size() + second_vals.size() > 0)
        begin
            if ($urandom_range(0, 31) == 0)
                send_beat(FUNC_UNUSED, $urandom);
            if (second_vals.size() == 0 || (first_vals.size() > 0 && $urandom_range(0, 1)))
                send_beat(FUNC_APPEND_FIRST, first_vals.pop_front());
            else
                send_beat(FUNC_APPEND_SECOND, second_vals.pop_front());
        end

        if (hold_off)
            drain_results();
        send_beat(FUNC_EVAL, $urandom);
    endtask

    function automatic int pick_size();
        if ($urandom_range(0, 99) < 4)
            return $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 6);
        return $urandom_range(0, 8);
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        res_stall = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // both lists empty
        send_beat(FUNC_EVAL, 32'h0000_0000);
        // empty first list is contained in anything
        send_beat(FUNC_APPEND_SECOND, 32'h0000_0000);
        send_beat(FUNC_EVAL, 32'hffff_ffff);
        // empty second list contained in a non-empty first
        send_beat(FUNC_APPEND_FIRST, 32'h8000_0000);
        send_beat(FUNC_EVAL, 32'h0000_0000);
        // signed extremes as plain bit patterns
        send_beat(FUNC_APPEND_FIRST, 32'h7fff_ffff);
        send_beat(FUNC_APPEND_FIRST, 32'h8000_0000);
        send_beat(FUNC_APPEND_SECOND, 32'h8000_0000);
        send_beat(FUNC_APPEND_SECOND, 32'hffff_ffff);
        send_beat(FUNC_APPEND_SECOND, 32'h7fff_ffff);
        send_beat(FUNC_EVAL, 32'h0000_0000);
        // duplicates, with an ignored command in the middle
        send_beat(FUNC_APPEND_FIRST, 32'd1);
        send_beat(FUNC_APPEND_FIRST, 32'd1);
        send_beat(FUNC_UNUSED, 32'd3);
        send_beat(FUNC_APPEND_FIRST, 32'd2);
        send_beat(FUNC_APPEND_SECOND, 32'd2);
        send_beat(FUNC_APPEND_SECOND, 32'd1);
        send_beat(FUNC_EVAL, 32'h0000_0000);
        // second list strictly within the first
        send_beat(FUNC_APPEND_FIRST, 32'd5);
        send_beat(FUNC_APPEND_FIRST, 32'd6);
        send_beat(FUNC_APPEND_SECOND, 32'd6);
        send_beat(FUNC_EVAL, 32'h0000_0000);
        // neither contained
        send_beat(FUNC_APPEND_FIRST, 32'd1);
        send_beat(FUNC_APPEND_SECOND, 32'd2);
        send_beat(FUNC_EVAL, 32'h0000_0000);
        drain_results();

        // both lists over capacity, then both exactly full
        send_set(LIST_DEPTH + 3, LIST_DEPTH + 1, SHAPE_FIRST_IN_SECOND, 1'b1);
        send_set(LIST_DEPTH, LIST_DEPTH, SHAPE_POOL, 1'b0);

        while (beats_sent < TARGET_BEATS)
        begin
            calm = (beats_sent >= CALM_AFTER);
            case ($urandom_range(0, 2))
                0: send_idle_pct = 0;
                1: send_idle_pct = 15;
                default: send_idle_pct = 45;
            endcase
            send_set(pick_size(), pick_size(), set_shape_t'($urandom_range(0, 3)),
                     $urandom_range(0, 9) == 0);
        end
        calm = 1'b1;

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d command beats and %0d evaluates, %0d results checked",
                 beats_sent, evals_sent, checked);
        $display("lists overran capacity in %0d sets, %0d mismatches", overflow_sets, errors);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== mutual_subset_check_core.f =====
+incdir+rtl
rtl/msc_pkg.sv
rtl/msc_ram.sv
rtl/msc_scan.sv
rtl/mutual_subset_check_core.sv
rtl/msc_checker.sv
tb/mutual_subset_check_checker.sv
tb/tb_mutual_subset_check_core.sv
